FILE: hdl/pics_pkg.sv
// pics_pkg: shared types for the point-in-capsule test pipeline
// used by pics_wide_mul and point_in_capsule_test_core, no dependencies
package pics_pkg;

   // number of register stages from input to result
   localparam int NUM_STAGES = 7;

   // load enables for the two register stages of the split multiplier
   typedef struct packed {
      logic ld_prod;
      logic ld_sum;
   } mul_en_type;

endpackage

FILE: hdl/pics_wide_mul.sv
// pics_wide_mul: unsigned 2H x 2H multiplier cut into four H x H partial products
// two register stages (partials, then recombine); needs pics_pkg
module pics_wide_mul
   import pics_pkg::*;
#(
   parameter int HALF_WIDTH = 17
) (
   input  logic                      clock,
   input  mul_en_type                mul_en,
   input  logic [2*HALF_WIDTH-1:0]   op_a,
   input  logic [2*HALF_WIDTH-1:0]   op_b,
   output logic [4*HALF_WIDTH-1:0]   prod
);

   localparam int H = HALF_WIDTH;

   logic [2*H-1:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic [2*H-1:0] ll_in, lh_in, hl_in, hh_in;
   logic [2*H:0]   mid;
   logic [4*H-1:0] prod_ff, prod_in;

   assign ll_in = {{H{1'b0}}, op_a[H-1:0]} * {{H{1'b0}}, op_b[H-1:0]};
   assign lh_in = {{H{1'b0}}, op_a[H-1:0]} * {{H{1'b0}}, op_b[2*H-1:H]};
   assign hl_in = {{H{1'b0}}, op_a[2*H-1:H]} * {{H{1'b0}}, op_b[H-1:0]};
   assign hh_in = {{H{1'b0}}, op_a[2*H-1:H]} * {{H{1'b0}}, op_b[2*H-1:H]};

   // cross terms summed, then placed at the middle weight
   assign mid     = {1'b0, lh_ff} + {1'b0, hl_ff};
   assign prod_in = {hh_ff, ll_ff} + {{(H-1){1'b0}}, mid, {H{1'b0}}};

   always_ff @(posedge clock) begin
      if (mul_en.ld_prod) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
      end
      if (mul_en.ld_sum) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

FILE: hdl/point_in_capsule_test_core.sv
// point_in_capsule_test_core: top level of the point-in-capsule test pipeline
// uses pics_pkg and two pics_wide_mul instances
//
// usage
//   req channel: one query item per accepted handshake (req_valid high, req_stall low):
//   query point, segment endpoints start and end, and an unsigned radius.
//   rsp channel: one item per query, rsp_inside_res is 1 when the point lies in the
//   capsule (within radius of either endpoint, or over the segment with perpendicular
//   distance at most radius; the boundary counts as inside).
//   the test is exact: t = (p-a).d, 0 <= t <= |d|^2 and
//   (|p-a|^2 - r^2)*|d|^2 <= t^2, all at full width, no square root.
//   pipeline: seven register stages, from the one that takes the query to the result
//   register that drives rsp_inside_res.
//   throughput: one item per cycle while rsp_stall is low; the two wide products are
//   split into four half-width partial products and recombined in the following stage.
//   rsp_stall holds the result register; stages behind it keep filling empty slots
//   so bubbles collapse, and req_stall rises only when every stage is occupied.
//   reset (synchronous, active high) clears all valid bits; payload is not reset.
module point_in_capsule_test_core
   import pics_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_start_z,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_z,
   input  logic        [COORD_WIDTH-1:0] req_radius,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_inside_res
);

   localparam int W      = COORD_WIDTH;
   localparam int DW     = W + 1;        // coordinate difference
   localparam int PW     = 2 * DW;       // product of two differences
   localparam int SUM_W  = 2 * W + 4;    // sum of three products, signed
   localparam int OP_W   = 2 * W + 2;    // operands of the final products
   localparam int HALF_W = W + 1;        // half of an operand

   // ---------------------------------------------------------------
   // stage control: a stage loads when it is empty or its content moves on
   // ---------------------------------------------------------------
   logic [NUM_STAGES:1]   vld_ff, vld_in;
   logic [NUM_STAGES+1:1] adv;

   always_comb begin
      adv[NUM_STAGES+1] = ~rsp_stall;
      for (int k = NUM_STAGES; k >= 1; k--) begin
         adv[k] = ~vld_ff[k] | adv[k+1];
      end
      vld_in = vld_ff;
      for (int k = NUM_STAGES; k >= 2; k--) begin
         if (adv[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
      if (adv[1]) begin
         vld_in[1] = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = ~adv[1];

   // ---------------------------------------------------------------
   // stage 1: differences p-a, p-b, d = b-a
   // ---------------------------------------------------------------
   logic signed [DW-1:0] pa_ff [3];
   logic signed [DW-1:0] pb_ff [3];
   logic signed [DW-1:0] dv_ff [3];
   logic        [W-1:0]  rad_ff;
   logic signed [W-1:0]  pt [3];
   logic signed [W-1:0]  sa [3];
   logic signed [W-1:0]  eb [3];

   assign pt[0] = req_point_x;
   assign pt[1] = req_point_y;
   assign pt[2] = req_point_z;
   assign sa[0] = req_start_x;
   assign sa[1] = req_start_y;
   assign sa[2] = req_start_z;
   assign eb[0] = req_end_x;
   assign eb[1] = req_end_y;
   assign eb[2] = req_end_z;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int i = 0; i < 3; i++) begin
            pa_ff[i] <= DW'(pt[i]) - DW'(sa[i]);
            pb_ff[i] <= DW'(pt[i]) - DW'(eb[i]);
            dv_ff[i] <= DW'(eb[i]) - DW'(sa[i]);
         end
         rad_ff <= req_radius;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: per-axis products and r^2
   // ---------------------------------------------------------------
   logic signed [PW-1:0] pa_sq_ff [3];
   logic signed [PW-1:0] pb_sq_ff [3];
   logic signed [PW-1:0] d_sq_ff  [3];
   logic signed [PW-1:0] pad_ff   [3];
   logic        [2*W-1:0] r_sq_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         for (int i = 0; i < 3; i++) begin
            pa_sq_ff[i] <= PW'(pa_ff[i]) * PW'(pa_ff[i]);
            pb_sq_ff[i] <= PW'(pb_ff[i]) * PW'(pb_ff[i]);
            d_sq_ff[i]  <= PW'(dv_ff[i]) * PW'(dv_ff[i]);
            pad_ff[i]   <= PW'(pa_ff[i]) * PW'(dv_ff[i]);
         end
         r_sq_ff <= {{W{1'b0}}, rad_ff} * {{W{1'b0}}, rad_ff};
      end
   end

   // ---------------------------------------------------------------
   // stage 3: squared lengths and projection t
   // ---------------------------------------------------------------
   logic signed [SUM_W-1:0] pa2_ff, pb2_ff, dd_ff, t_ff, r2_ff;

   function automatic logic signed [SUM_W-1:0] sum3(input logic signed [PW-1:0] v [3]);
      logic signed [SUM_W-1:0] acc;
      acc = SUM_W'(v[0]) + SUM_W'(v[1]) + SUM_W'(v[2]);
      return acc;
   endfunction

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         pa2_ff <= sum3(pa_sq_ff);
         pb2_ff <= sum3(pb_sq_ff);
         dd_ff  <= sum3(d_sq_ff);
         t_ff   <= sum3(pad_ff);
         r2_ff  <= {4'b0000, r_sq_ff};
      end
   end

   // ---------------------------------------------------------------
   // stage 4: endpoint test, segment range test, operands for the last check
   // ---------------------------------------------------------------
   logic                    end_hit, seg_fail;
   logic signed [SUM_W-1:0] excess;
   logic [OP_W-1:0]         excess_ff, dd4_ff, t4_ff;
   logic                    hit4_ff, fail4_ff;

   assign end_hit  = (pa2_ff <= r2_ff) || (pb2_ff <= r2_ff);
   // zero-length segment, or projection before the start or past the end
   assign seg_fail = (dd_ff == '0) || (t_ff < 0) || (t_ff > dd_ff);
   assign excess   = pa2_ff - r2_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         hit4_ff   <= end_hit;
         fail4_ff  <= ~end_hit & seg_fail;
         excess_ff <= excess[OP_W-1:0];
         dd4_ff    <= dd_ff[OP_W-1:0];
         t4_ff     <= t_ff[OP_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // stages 5 and 6: (|p-a|^2 - r^2)*|d|^2 and t^2, split multipliers
   // ---------------------------------------------------------------
   mul_en_type           mul_en;
   logic [2*OP_W-1:0]    lhs, rhs;
   logic                 hit5_ff, fail5_ff, hit6_ff, fail6_ff;

   assign mul_en.ld_prod = adv[5];
   assign mul_en.ld_sum  = adv[6];

   pics_wide_mul #(
      .HALF_WIDTH (HALF_W)
   ) u_lhs_mul (
      .clock  (clock),
      .mul_en (mul_en),
      .op_a   (excess_ff),
      .op_b   (dd4_ff),
      .prod   (lhs)
   );

   pics_wide_mul #(
      .HALF_WIDTH (HALF_W)
   ) u_rhs_mul (
      .clock  (clock),
      .mul_en (mul_en),
      .op_a   (t4_ff),
      .op_b   (t4_ff),
      .prod   (rhs)
   );

   // early decisions ride along with the products
   always_ff @(posedge clock) begin
      if (adv[5]) begin
         hit5_ff  <= hit4_ff;
         fail5_ff <= fail4_ff;
      end
      if (adv[6]) begin
         hit6_ff  <= hit5_ff;
         fail6_ff <= fail5_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 7: final compare into the result register
   // ---------------------------------------------------------------
   logic inside_ff, inside_in;

   assign inside_in = hit6_ff | (~fail6_ff & (lhs <= rhs));

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         inside_ff <= inside_in;
      end
   end

   assign rsp_valid      = vld_ff[NUM_STAGES];
   assign rsp_inside_res = inside_ff;

endmodule

FILE: tb/point_in_capsule_test_core_tb.sv
// point_in_capsule_test_core_tb: self-checking bench for the point-in-capsule pipeline
// depends on pics_pkg and point_in_capsule_test_core; exact integer predictor inside
`timescale 1ns / 100ps

module point_in_capsule_test_core_tb
   import pics_pkg::*;
();

   localparam int CW = 16;

   // one query as it goes over the req channel
   typedef struct packed {
      logic signed [CW-1:0] px;
      logic signed [CW-1:0] py;
      logic signed [CW-1:0] pz;
      logic signed [CW-1:0] ax;
      logic signed [CW-1:0] ay;
      logic signed [CW-1:0] az;
      logic signed [CW-1:0] bx;
      logic signed [CW-1:0] by;
      logic signed [CW-1:0] bz;
      logic [CW-1:0]        radius;
   } query_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // req channel, every input known from time zero
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   logic signed [CW-1:0] req_point_x = '0;
   logic signed [CW-1:0] req_point_y = '0;
   logic signed [CW-1:0] req_point_z = '0;
   logic signed [CW-1:0] req_start_x = '0;
   logic signed [CW-1:0] req_start_y = '0;
   logic signed [CW-1:0] req_start_z = '0;
   logic signed [CW-1:0] req_end_x   = '0;
   logic signed [CW-1:0] req_end_y   = '0;
   logic signed [CW-1:0] req_end_z   = '0;
   logic [CW-1:0]        req_radius  = '0;

   // rsp channel
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_inside_res;

   // queries waiting to be driven, and verdicts waiting for their result item
   query_type pending_queries[$];
   bit        inside_expected[$];
   int        mismatch_cnt = 0;

   // driver state
   query_type issued_query;
   int        send_gap   = 0;
   bit        send_burst = 1'b0;

   // receiver state
   int     stall_left = 0;
   int     stall_draw = 0;
   bit     rsp_burst  = 1'b0;

   always #10 clock = ~clock;

   point_in_capsule_test_core #(
      .COORD_WIDTH(CW)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_start_z    (req_start_z),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_end_z      (req_end_z),
      .req_radius     (req_radius),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_inside_res (rsp_inside_res)
   );

   // exact capsule membership: endpoint spheres first, then the slab and
   // perpendicular distance test with t = (p-a).d kept unnormalized.
   // squared lengths fit in 64 bits, their products need the wide compare
   function automatic bit capsule_contains(query_type q);
      longint p[3], a[3], b[3], pa[3], pb[3], d[3];
      longint pa2, pb2, dd, r2, t;
      logic signed [127:0] excess, proj;
      int i;
      p[0] = $signed(q.px);  p[1] = $signed(q.py);  p[2] = $signed(q.pz);
      a[0] = $signed(q.ax);  a[1] = $signed(q.ay);  a[2] = $signed(q.az);
      b[0] = $signed(q.bx);  b[1] = $signed(q.by);  b[2] = $signed(q.bz);
      r2  = longint'(q.radius) * longint'(q.radius);
      pa2 = 0;
      pb2 = 0;
      dd  = 0;
      t   = 0;
      for (i = 0; i < 3; i++) begin
         pa[i] = p[i] - a[i];
         pb[i] = p[i] - b[i];
         d[i]  = b[i] - a[i];
         pa2  += pa[i] * pa[i];
         pb2  += pb[i] * pb[i];
         dd   += d[i] * d[i];
         t    += pa[i] * d[i];
      end
      // boundary counts as inside
      if (pa2 <= r2 || pb2 <= r2)
         return 1'b1;
      // degenerate segment: only the endpoint spheres count
      if (dd == 0)
         return 1'b0;
      // projection must land between the endpoints
      if (t < 0 || t > dd)
         return 1'b0;
      excess = pa2 - r2;
      excess = excess * dd;
      proj   = t;
      proj   = proj * t;
      return excess <= proj;
   endfunction

   function automatic query_type make_query(int px, int py, int pz, int ax, int ay, int az,
                                            int bx, int by, int bz, int r);
      query_type q;
      q.px = CW'(px);  q.py = CW'(py);  q.pz = CW'(pz);
      q.ax = CW'(ax);  q.ay = CW'(ay);  q.az = CW'(az);
      q.bx = CW'(bx);  q.by = CW'(by);  q.bz = CW'(bz);
      q.radius = CW'(r);
      return q;
   endfunction

   // uniform integer in [lo, hi]
   function automatic int rand_span(int lo, int hi);
      return int'($urandom_range(hi - lo, 0)) + lo;
   endfunction

   // coordinate biased toward the ends of the signed range, zero and minus one
   function automatic int pick_extreme();
      case ($urandom_range(4, 0))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return -1;
         default: return rand_span(-32768, 32767);
      endcase
   endfunction

   // wait cycles drawn per item; burst stretches run with no idling at all
   function automatic int draw_wait(bit burst);
      return burst ? 0 : int'($urandom_range(13, 0));
   endfunction

   // random query, mostly shaped so the point sits close to a capsule surface
   function automatic query_type random_query();
      int pv[3], av[3], bv[3];
      int r, k, spread, base, i;
      case ($urandom_range(9, 0))
         0, 1, 2: begin
            // anything goes: exercises every input bit
            for (i = 0; i < 3; i++) begin
               pv[i] = rand_span(-32768, 32767);
               av[i] = rand_span(-32768, 32767);
               bv[i] = rand_span(-32768, 32767);
            end
            r = rand_span(0, 65535);
         end
         3, 4: begin
            // tiny cluster somewhere in space, radius of the same size
            for (i = 0; i < 3; i++) begin
               base  = rand_span(-30000, 30000);
               pv[i] = base + rand_span(-16, 16);
               av[i] = base + rand_span(-16, 16);
               bv[i] = base + rand_span(-16, 16);
            end
            r = rand_span(0, 24);
         end
         5, 6, 7, 8: begin
            // point near the segment, slightly past either end at times;
            // at least one in four is a zero-length segment
            k      = rand_span(-1, 9);
            spread = $urandom_range(1, 0) ? 3 : 300;
            for (i = 0; i < 3; i++) begin
               av[i] = rand_span(-16000, 16000);
               bv[i] = ($urandom_range(3, 0) == 0) ? av[i] : rand_span(-16000, 16000);
            end
            if ($urandom_range(3, 0) == 0)
               bv = av;
            for (i = 0; i < 3; i++)
               pv[i] = av[i] + (bv[i] - av[i]) * k / 8 + rand_span(-spread, spread);
            r = rand_span(0, 2 * spread);
         end
         default: begin
            // corners of the coordinate range
            for (i = 0; i < 3; i++) begin
               pv[i] = pick_extreme();
               av[i] = pick_extreme();
               bv[i] = pick_extreme();
            end
            case ($urandom_range(2, 0))
               0: r = 0;
               1: r = 65535;
               default: r = rand_span(0, 65535);
            endcase
         end
      endcase
      return make_query(pv[0], pv[1], pv[2], av[0], av[1], av[2],
                        bv[0], bv[1], bv[2], r);
   endfunction

   // driver: one item per handshake, random gap before the next item
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         // item taken at this edge: its verdict joins the expected queue
         if (req_valid && !req_stall)
            inside_expected.push_back(capsule_contains(issued_query));
         // the payload is only replaced once the current item is gone
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (pending_queries.size() > 0) begin
               issued_query = pending_queries.pop_front();
               req_point_x <= issued_query.px;
               req_point_y <= issued_query.py;
               req_point_z <= issued_query.pz;
               req_start_x <= issued_query.ax;
               req_start_y <= issued_query.ay;
               req_start_z <= issued_query.az;
               req_end_x   <= issued_query.bx;
               req_end_y   <= issued_query.by;
               req_end_z   <= issued_query.bz;
               req_radius  <= issued_query.radius;
               req_valid   <= 1'b1;
               if ($urandom_range(39, 0) == 0)
                  send_burst = ~send_burst;
               send_gap <= draw_wait(send_burst);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each accepted result item, then may stall for a random stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (inside_expected.size() == 0) begin
            $display("%0t: inside_res with no query outstanding, expected none, actual %0b",
                     $time, rsp_inside_res);
            mismatch_cnt++;
         end else if (inside_expected[0] !== rsp_inside_res) begin
            $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                     $time, inside_expected[0], rsp_inside_res);
            mismatch_cnt++;
            void'(inside_expected.pop_front());
         end else begin
            void'(inside_expected.pop_front());
         end
         if ($urandom_range(39, 0) == 0)
            rsp_burst = ~rsp_burst;
         // one draw sets both the stall flag and its length
         stall_draw = draw_wait(rsp_burst);
         stall_left <= stall_draw;
         rsp_stall  <= (stall_draw != 0);
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end
   end

   // stimulus and end of run
   initial begin
      // directed part
      // point on the start endpoint, zero radius
      pending_queries.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // zero-length segment: exactly on the sphere, then just outside
      pending_queries.push_back(make_query(3, 4, 0, 0, 0, 0, 0, 0, 0, 5));
      pending_queries.push_back(make_query(3, 4, 0, 0, 0, 0, 0, 0, 0, 4));
      // perpendicular distance equal to the radius, then one less
      pending_queries.push_back(make_query(5, 3, 0, 0, 0, 0, 10, 0, 0, 3));
      pending_queries.push_back(make_query(5, 3, 0, 0, 0, 0, 10, 0, 0, 2));
      // zero radius: on the segment, then one unit off it
      pending_queries.push_back(make_query(5, 0, 0, 0, 0, 0, 10, 0, 0, 0));
      pending_queries.push_back(make_query(5, 1, 0, 0, 0, 0, 10, 0, 0, 0));
      // projection past the end, then before the start
      pending_queries.push_back(make_query(15, 0, 0, 0, 0, 0, 10, 0, 0, 3));
      pending_queries.push_back(make_query(-4, 0, 0, 0, 0, 0, 10, 0, 0, 3));
      // end endpoint sphere boundary
      pending_queries.push_back(make_query(13, 4, 0, 0, 0, 0, 10, 0, 0, 5));
      // all fields at the top and at the bottom of their range
      pending_queries.push_back(make_query(32767, 32767, 32767, 32767, 32767, 32767,
                                           32767, 32767, 32767, 65535));
      pending_queries.push_back(make_query(-32768, -32768, -32768, -32768, -32768, -32768,
                                           -32768, -32768, -32768, 0));
      // largest distance from a degenerate segment, largest radius; then a diagonal
      pending_queries.push_back(make_query(32767, 32767, 32767, -32768, -32768, -32768,
                                           -32768, -32768, -32768, 65535));
      pending_queries.push_back(make_query(32767, 32767, 32767, -32768, -32768, -32768,
                                           32767, -32768, 32767, 0));
      // longest segment: point on the diagonal, then one unit off it
      pending_queries.push_back(make_query(0, 0, 0, -32768, -32768, -32768,
                                           32767, 32767, 32767, 0));
      pending_queries.push_back(make_query(0, 0, 1, -32768, -32768, -32768,
                                           32767, 32767, 32767, 0));
      pending_queries.push_back(make_query(0, 0, 1, -32768, -32768, -32768,
                                           32767, 32767, 32767, 1));
      // long axis segment, radius at the perpendicular distance and one below
      pending_queries.push_back(make_query(0, 32767, 0, -32768, 0, 0, 32767, 0, 0, 32767));
      pending_queries.push_back(make_query(0, 32767, 0, -32768, 0, 0, 32767, 0, 0, 32766));
      // negative coordinates, boundary off a z-directed segment
      pending_queries.push_back(make_query(-97, -96, 0, -100, -100, -100,
                                           -100, -100, 100, 5));
      pending_queries.push_back(make_query(-97, -96, 0, -100, -100, -100,
                                           -100, -100, 100, 4));

      // random part
      repeat (1550)
         pending_queries.push_back(random_query());

      // single reset pulse
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // every item handed over
      while (pending_queries.size() != 0 || req_valid)
         @(posedge clock);
      // every verdict seen
      while (inside_expected.size() != 0)
         @(posedge clock);
      // then wait on to catch stray result items
      repeat (4 * NUM_STAGES) @(posedge clock);

      if (mismatch_cnt == 0)
         $display("point_in_capsule_test_core regression: pass");
      else
         $display("point_in_capsule_test_core regression: fail");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("point_in_capsule_test_core regression: fail");
      $finish;
   end

endmodule

FILE: sim.f
hdl/pics_pkg.sv
hdl/pics_wide_mul.sv
hdl/point_in_capsule_test_core.sv
tb/point_in_capsule_test_core_tb.sv
